// File: hw/rtl/cod_pkg.sv
// ----------------------------------------------------------------------------
// cod_pkg
// Shared types, constants and helpers of the causal delivery block.
// ----------------------------------------------------------------------------
`default_nettype none
package cod_pkg;
	localparam int NUM_PROCS  = 4;
	localparam int CLOCK_BITS = 16;
	localparam int HOLD_DEPTH = 16;
	localparam int HOLD_AW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
	localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
	localparam int STAMP_W    = 64;
	localparam int HELD_W     = 2 + 16 + STAMP_W;
	localparam int QDEPTH     = 2;

	localparam logic [2:0] KIND_SENT      = 3'd0;
	localparam logic [2:0] KIND_ARRIVED   = 3'd1;
	localparam logic [2:0] KIND_DELIVERED = 3'd2;
	localparam logic [2:0] KIND_DROPPED   = 3'd3;
	localparam logic [2:0] KIND_OVERFLOW  = 3'd4;

	localparam logic [0:0] REG_SELF_ID = 1'b0;
	localparam logic [0:0] REG_ACTIVE  = 1'b1;

	typedef logic [15:0] entry_t;
	typedef entry_t [NUM_PROCS-1:0] vclock_t;

	localparam entry_t CLK_MAX = entry_t'((17'd1 << CLOCK_BITS) - 17'd1);

	typedef struct packed {
		logic        req_type;
		logic [1:0]  sender;
		logic [15:0] msg_id;
		logic [63:0] stamp;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  from_id;
		logic [15:0] report_id;
		logic [63:0] clock_now;
		logic        last;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DROP, ST_SCAN_RD, ST_SCAN, ST_SHIFT
	} state_t;

	function automatic entry_t st_entry(input logic [63:0] st, input int k);
		entry_t e;
		e = st[16*k +: 16];
		return e & CLK_MAX;
	endfunction

	function automatic logic [63:0] pack_clk(input vclock_t c);
		logic [63:0] v;
		v = '0;
		for (int k = 0; k < NUM_PROCS; k++) v[16*k +: 16] = c[k];
		return v;
	endfunction

	function automatic logic can_deliver(input logic [1:0] snd, input logic [63:0] st,
			input vclock_t c, input logic [2:0] n);
		logic ok;
		entry_t s;
		ok = {1'b0, snd} < n;
		for (int k = 0; k < NUM_PROCS; k++)
			if (3'(k) < n && 2'(k) != snd && st_entry(st, k) > c[k]) ok = 1'b0;
		s = st_entry(st, 0);
		for (int k = 1; k < NUM_PROCS; k++) if (2'(k) == snd) s = st_entry(st, k);
		for (int k = 0; k < NUM_PROCS; k++)
			if (2'(k) == snd && (s == '0 || s - 16'd1 != c[k])) ok = 1'b0;
		return ok;
	endfunction

	function automatic vclock_t merge_clk(input logic [63:0] st, input vclock_t c,
			input logic [2:0] n);
		vclock_t r;
		r = c;
		for (int k = 0; k < NUM_PROCS; k++)
			if (3'(k) < n && st_entry(st, k) > c[k]) r[k] = st_entry(st, k);
		return r;
	endfunction
endpackage
`default_nettype wire

// File: hw/rtl/cod_if.sv
// ----------------------------------------------------------------------------
// cod_req_if / cod_rsp_if
// Valid/ready channels carrying requests and reports.
// ----------------------------------------------------------------------------
`default_nettype none
interface cod_req_if;
	logic           valid;
	logic           ready;
	cod_pkg::req_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cod_rsp_if;
	logic           valid;
	logic           ready;
	cod_pkg::rsp_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cod_ram.sv
// ----------------------------------------------------------------------------
// cod_ram
// Generic single-write RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module cod_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: hw/rtl/cod_front.sv
// ----------------------------------------------------------------------------
// cod_front
// Input side: accepts items into a short queue ahead of the engine.
// ----------------------------------------------------------------------------
`default_nettype none
module cod_front (
	input  wire logic    clk,
	input  wire logic    arst_n,
	cod_req_if.sink      in_ch,
	cod_req_if.source    q_ch
);
	cod_pkg::req_t buf_q [cod_pkg::QDEPTH];
	logic          rd_q, wr_q;
	logic [1:0]    cnt_q;
	logic          push, pop;

	assign in_ch.ready = cnt_q != 2'(cod_pkg::QDEPTH);
	assign push = in_ch.valid && in_ch.ready;
	assign pop = q_ch.valid && q_ch.ready;
	assign q_ch.valid = cnt_q != 2'd0;
	assign q_ch.data = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= in_ch.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/cod_engine.sv
// ----------------------------------------------------------------------------
// cod_engine
// Back end: clock update, hold store, rescans and reports.
// ----------------------------------------------------------------------------
`default_nettype none
module cod_engine (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [1:0]          self_id,
	input  wire logic [2:0]          eff_n,
	cod_req_if.sink                  q_ch,
	cod_rsp_if.source                out_ch
);
	cod_pkg::state_t             state_q, state_d;
	cod_pkg::vclock_t            clk_q, clk_d;
	logic [cod_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	logic [cod_pkg::CNT_W-1:0]   idx_q, idx_d;
	logic                        found_q, found_d;
	logic                        pend_q, pend_d;
	cod_pkg::rsp_t               pend_data_q, pend_data_d;
	logic                        ov_q, ov_d;
	cod_pkg::rsp_t               ov_data_q, ov_data_d;
	logic                        take;
	logic                        gen;
	cod_pkg::rsp_t               gen_data;
	logic                        fin;
	logic                        we;
	logic [cod_pkg::HOLD_AW-1:0] waddr, raddr;
	logic [cod_pkg::HELD_W-1:0]  wdata, rdata;
	logic [1:0]                  hs;
	logic [15:0]                 hm;
	logic [63:0]                 ht;

	cod_ram #(.WIDTH(cod_pkg::HELD_W), .DEPTH(cod_pkg::HOLD_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign {hs, hm, ht} = rdata;
	assign out_ch.valid = ov_q;
	assign out_ch.data = ov_data_q;
	// Results leave through a single register; work stalls while it is full and not accepted.
	// The newest report waits in a staging register until it is known whether
	// it is the final one of its item.
	assign take = !ov_q || out_ch.ready;
	assign q_ch.ready = state_q == cod_pkg::ST_IDLE && take;

	always_comb begin
		state_d = state_q;
		clk_d = clk_q;
		cnt_d = cnt_q;
		idx_d = idx_q;
		found_d = found_q;
		pend_d = pend_q;
		pend_data_d = pend_data_q;
		ov_d = ov_q;
		ov_data_d = ov_data_q;
		gen = 1'b0;
		gen_data = pend_data_q;
		fin = 1'b0;
		we = 1'b0;
		waddr = cnt_q[cod_pkg::HOLD_AW-1:0];
		wdata = {q_ch.data.sender, q_ch.data.msg_id, q_ch.data.stamp};
		if (take) ov_d = 1'b0;
		unique case (state_q)
			cod_pkg::ST_IDLE: begin
				if (q_ch.valid && take) begin
					gen_data.from_id = q_ch.data.req_type ? q_ch.data.sender : self_id;
					gen_data.report_id = q_ch.data.msg_id;
					gen_data.last = 1'b0;
					gen_data.clock_now = cod_pkg::pack_clk(clk_q);
					if (!q_ch.data.req_type) begin
						if (clk_q[self_id] >= cod_pkg::CLK_MAX) begin
							gen_data.kind = cod_pkg::KIND_OVERFLOW;
						end else begin
							gen_data.kind = cod_pkg::KIND_SENT;
							clk_d[self_id] = clk_q[self_id] + 16'd1;
							gen_data.clock_now = cod_pkg::pack_clk(clk_d);
						end
						gen_data.last = 1'b1;
						ov_d = 1'b1;
						ov_data_d = gen_data;
					end else begin
						gen = 1'b1;
						gen_data.kind = cod_pkg::KIND_ARRIVED;
						idx_d = '0;
						if (cod_pkg::can_deliver(q_ch.data.sender, q_ch.data.stamp,
								clk_q, eff_n)) begin
							clk_d = cod_pkg::merge_clk(q_ch.data.stamp, clk_q, eff_n);
							found_d = 1'b1;
							state_d = cod_pkg::ST_DROP;
						end else if (cnt_q < cod_pkg::CNT_W'(cod_pkg::HOLD_DEPTH)) begin
							we = 1'b1;
							cnt_d = cnt_q + 1'b1;
							state_d = cod_pkg::ST_SCAN_RD;
						end else begin
							found_d = 1'b0;
							state_d = cod_pkg::ST_DROP;
						end
					end
				end
			end
			cod_pkg::ST_DROP: begin
				if (take) begin
					gen = 1'b1;
					gen_data.kind = found_q ? cod_pkg::KIND_DELIVERED : cod_pkg::KIND_DROPPED;
					gen_data.clock_now = cod_pkg::pack_clk(clk_q);
					idx_d = '0;
					state_d = cod_pkg::ST_SCAN_RD;
				end
			end
			cod_pkg::ST_SCAN_RD: begin
				if (take) begin
					if (idx_q >= cnt_q) begin
						fin = 1'b1;
						state_d = cod_pkg::ST_IDLE;
					end else begin
						state_d = cod_pkg::ST_SCAN;
					end
				end
			end
			cod_pkg::ST_SCAN: begin
				if (take) begin
					if (cod_pkg::can_deliver(hs, ht, clk_q, eff_n)) begin
						clk_d = cod_pkg::merge_clk(ht, clk_q, eff_n);
						gen = 1'b1;
						gen_data.kind = cod_pkg::KIND_DELIVERED;
						gen_data.from_id = hs;
						gen_data.report_id = hm;
						gen_data.clock_now = cod_pkg::pack_clk(clk_d);
						if (idx_q + 1'b1 < cnt_q) begin
							state_d = cod_pkg::ST_SHIFT;
						end else begin
							cnt_d = cnt_q - 1'b1;
							idx_d = '0;
							state_d = cod_pkg::ST_SCAN_RD;
						end
					end else if (idx_q + 1'b1 >= cnt_q) begin
						fin = 1'b1;
						state_d = cod_pkg::ST_IDLE;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			cod_pkg::ST_SHIFT: begin
				if (take) begin
					we = 1'b1;
					waddr = idx_q[cod_pkg::HOLD_AW-1:0];
					wdata = rdata;
					if (idx_q + cod_pkg::CNT_W'(2) < cnt_q) begin
						idx_d = idx_q + 1'b1;
					end else begin
						cnt_d = cnt_q - 1'b1;
						idx_d = '0;
						state_d = cod_pkg::ST_SCAN_RD;
					end
				end
			end
			default: state_d = cod_pkg::ST_IDLE;
		endcase
		if (gen) begin
			if (pend_q) begin
				ov_d = 1'b1;
				ov_data_d = pend_data_q;
				ov_data_d.last = 1'b0;
			end
			pend_d = 1'b1;
			pend_data_d = gen_data;
		end
		if (fin) begin
			ov_d = 1'b1;
			ov_data_d = pend_data_q;
			ov_data_d.last = 1'b1;
			pend_d = 1'b0;
		end
		// The read address follows the next state so that a stall keeps the
		// entry that the current state needs.
		if (state_d == cod_pkg::ST_SHIFT)
			raddr = idx_d[cod_pkg::HOLD_AW-1:0] + cod_pkg::HOLD_AW'(1);
		else
			raddr = idx_d[cod_pkg::HOLD_AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cod_pkg::ST_IDLE;
			clk_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			pend_q <= 1'b0;
			pend_data_q <= '0;
			ov_q <= 1'b0;
			ov_data_q <= '0;
		end else begin
			state_q <= state_d;
			clk_q <= clk_d;
			cnt_q <= cnt_d;
			idx_q <= idx_d;
			found_q <= found_d;
			pend_q <= pend_d;
			pend_data_q <= pend_data_d;
			ov_q <= ov_d;
			ov_data_q <= ov_data_d;
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/causal_order_delivery.sv
// ----------------------------------------------------------------------------
// causal_order_delivery
// One node of causal broadcast ordering with vector clocks.
// ----------------------------------------------------------------------------
// A send is taken in the idle state and its result is presented from the
// result register in the cycle after the engine takes the item. A received
// message passes the idle state, a report step when it is delivered or dropped
// on arrival, and rescan passes that examine held entries in turn; each delivery
// from the hold store moves the later entries down one by one and restarts the
// pass. Every step waits while the result register holds an unaccepted item.
// Configuration must be written only while idle; the block does not enforce it.
`default_nettype none
module causal_order_delivery (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [2:0]  cfg_data,
	cod_req_if.sink          in_ch,
	cod_rsp_if.source        out_ch
);
	logic [1:0] self_id_q;
	logic [2:0] active_q;
	logic [2:0] eff_n;

	cod_req_if q_if ();

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_id_q <= 2'd0;
			active_q <= 3'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				cod_pkg::REG_SELF_ID: self_id_q <= cfg_data[1:0];
				cod_pkg::REG_ACTIVE: active_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign eff_n = active_q > 3'(cod_pkg::NUM_PROCS) ? 3'(cod_pkg::NUM_PROCS) : active_q;

	cod_front u_front (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .q_ch(q_if.source));

	cod_engine u_engine (
		.clk(clk), .arst_n(arst_n), .self_id(self_id_q), .eff_n(eff_n),
		.q_ch(q_if.sink), .out_ch(out_ch)
	);
endmodule
`default_nettype wire
